@@ rtl/bfoa_pkg.sv @@
// Shared types and constants for the best-fit offset allocator.
`default_nettype none
package bfoa_pkg;

   localparam int CAPACITY   = 64;
   localparam int VALUE_BITS = 31;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   localparam logic KIND_FREE    = 1'b0;
   localparam logic KIND_REQUEST = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic [VALUE_BITS-1:0] block_size;
      logic [VALUE_BITS-1:0] block_offset;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] granted_offset;
      logic                  found;
      logic                  table_full;
      logic [CNT_W-1:0]      entry_count;
   } rsp_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] size;
      logic [VALUE_BITS-1:0] offset;
   } entry_type;

   typedef struct packed {
      logic                  have;
      logic [VALUE_BITS-1:0] size;
      logic [VALUE_BITS-1:0] offset;
      logic [IDX_W-1:0]      idx;
   } token_type;

   typedef struct packed {
      logic valid;
      logic shift;
      logic load;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

@@ rtl/bfoa_cell.sv @@
// One table cell: holds a free block and refines the best-fit token passing through.
`default_nettype none
module bfoa_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  bfoa_pkg::cell_ctl_type            ctl,
   input  logic [bfoa_pkg::IDX_W-1:0]        cell_index,
   input  logic [bfoa_pkg::VALUE_BITS-1:0]   want,
   input  bfoa_pkg::entry_type               load_entry,
   input  bfoa_pkg::entry_type               next_entry,
   output bfoa_pkg::entry_type               entry,
   input  bfoa_pkg::token_type               prev_tok,
   output bfoa_pkg::token_type               tok_out
);
   import bfoa_pkg::*;

   entry_type entry_ff, entry_in;
   token_type tok_ff, tok_in;
   logic      hit;

   always_comb begin
      hit = ctl.valid && (entry_ff.size >= want) &&
            (!prev_tok.have || (entry_ff.size < prev_tok.size));
      tok_in = prev_tok;
      if (hit) begin
         tok_in.have   = 1'b1;
         tok_in.size   = entry_ff.size;
         tok_in.offset = entry_ff.offset;
         tok_in.idx    = cell_index;
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load) begin
         entry_in = load_entry;
      end else if (ctl.shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign entry   = entry_ff;
   assign tok_out = tok_ff;

endmodule
`default_nettype wire

@@ rtl/best_fit_offset_allocator_core.sv @@
// Top level of the best-fit offset allocator: cell row, sequencer and result register.
//
// The free-block table lives in a row of CAPACITY cells, oldest block in cell 0. A free
// transfer appends its block in the update state, and its result is then registered. A
// request sends a best-fit token down the cell row, one cell per cycle, during the search
// state, then passes through the update and result states. One item is in flight at a time:
// a new item is taken only once the previous result has moved into the output register,
// where a finished result waits while the next item is taken.
`default_nettype none
module best_fit_offset_allocator_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bfoa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bfoa_pkg::rsp_type rsp_data
);
   import bfoa_pkg::*;

   state_type             state_ff, state_in;
   req_type               item_ff, item_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      search_cnt_ff, search_cnt_in;
   rsp_type               res_ff, res_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  req_take;
   logic                  search_last;
   logic                  rsp_load;
   logic                  is_req;
   logic                  free_ok;
   logic                  do_grant;
   logic                  do_free;
   logic                  rest_nz;
   logic [VALUE_BITS-1:0] rest;
   logic [VALUE_BITS-1:0] rest_offset;
   token_type             best;
   entry_type             load_entry;

   entry_type             cell_q   [CAPACITY];
   token_type             cell_tok [CAPACITY];
   cell_ctl_type          cell_ctl [CAPACITY];

   assign best        = cell_tok[CAPACITY-1];
   assign is_req      = (item_ff.kind == KIND_REQUEST);
   assign free_ok     = (count_ff < CNT_W'(CAPACITY));
   assign rest        = best.size - item_ff.block_size;
   assign rest_offset = best.offset + item_ff.block_size;
   assign rest_nz     = (rest != '0);
   assign do_grant    = (state_ff == ST_UPDATE) && is_req && best.have;
   assign do_free     = (state_ff == ST_UPDATE) && !is_req && free_ok;
   assign search_last = (search_cnt_ff == IDX_W'(CAPACITY - 1));

   always_comb begin
      if (do_free) begin
         load_entry.size   = item_ff.block_size;
         load_entry.offset = item_ff.block_offset;
      end else begin
         load_entry.size   = rest;
         load_entry.offset = rest_offset;
      end
   end

   for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
      token_type prev_tok;
      entry_type next_entry;

      if (j == 0) begin : g_head
         assign prev_tok = '0;
      end else begin : g_link
         assign prev_tok = cell_tok[j-1];
      end

      if (j == CAPACITY - 1) begin : g_tail
         assign next_entry = cell_q[j];
      end else begin : g_next
         assign next_entry = cell_q[j+1];
      end

      always_comb begin
         cell_ctl[j].valid = (CNT_W'(j) < count_ff);
         cell_ctl[j].shift = do_grant && (IDX_W'(j) >= best.idx) &&
                             (CNT_W'(j + 1) < count_ff);
         cell_ctl[j].load  = (do_grant && rest_nz && (CNT_W'(j + 1) == count_ff)) ||
                             (do_free && (CNT_W'(j) == count_ff));
      end

      bfoa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl[j]),
         .cell_index (IDX_W'(j)),
         .want       (item_ff.block_size),
         .load_entry (load_entry),
         .next_entry (next_entry),
         .entry      (cell_q[j]),
         .prev_tok   (prev_tok),
         .tok_out    (cell_tok[j])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.kind == KIND_REQUEST) ? ST_SEARCH : ST_UPDATE;
            end
         end
         ST_SEARCH: begin
            if (search_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall = 1'b1;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign req_take = req_valid && !req_stall;

   always_comb begin
      item_in       = req_take ? req_data : item_ff;
      search_cnt_in = '0;
      if (state_ff == ST_SEARCH) begin
         search_cnt_in = search_cnt_ff + IDX_W'(1);
      end

      count_in = count_ff;
      if (do_free) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_grant && !rest_nz) begin
         count_in = count_ff - CNT_W'(1);
      end

      res_in = res_ff;
      if (state_ff == ST_UPDATE) begin
         res_in.granted_offset = do_grant ? best.offset : '0;
         res_in.found          = do_grant;
         res_in.table_full     = !is_req && !free_ok;
         res_in.entry_count    = count_in;
      end

      rsp_in       = rsp_load ? res_ff : rsp_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         search_cnt_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         search_cnt_ff <= search_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("Entry count exceeds the table capacity.");

   a_grant_no_growth: assert property (@(posedge clock) disable iff (reset)
      do_grant |=> count_ff <= $past(count_ff))
      else $error("A granted request grew the table.");

   a_found_full_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.found && rsp_ff.table_full))
      else $error("A result reports both a grant and a dropped block.");

   a_no_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff.granted_offset == '0))
      else $error("A result without a grant carries a nonzero offset.");

   a_search_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && search_last) |=> state_ff == ST_UPDATE)
      else $error("The search sweep did not end in an update.");

endmodule
`default_nettype wire

@@ tb/tb_best_fit_offset_allocator_core.sv @@
// Self-checking testbench for best_fit_offset_allocator_core: directed table, random traffic.
`default_nettype none
module tb_best_fit_offset_allocator_core;
   import bfoa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIRECTED_FILL = CAPACITY - 2;
   localparam int RANDOM_ITEMS  = 1870;
   localparam int IDLE_PCT      = 33;
   localparam int DRAIN_CYCLES  = 3 * CAPACITY;
   localparam int WATCHDOG_MAX  = 20 * CAPACITY;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

   typedef struct packed {
      req_type     item;
      logic [15:0] reps;
      logic        typed;
      rsp_type     want;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic                  steady = 1'b0;
   logic [VALUE_BITS-1:0] held_sizes [CAPACITY];
   logic [VALUE_BITS-1:0] held_offsets [CAPACITY];
   int                    held_blocks = 0;
   rsp_type               pending_grants [$];
   plan_row_type          plan [$];
   int                    fail_count = 0;
   int                    quiet_cycles = 0;

   best_fit_offset_allocator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_type best_fit_step(req_type item);
      rsp_type               r;
      int                    best;
      logic [VALUE_BITS-1:0] rest;
      logic [VALUE_BITS-1:0] base;
      r = '0;
      best = -1;
      if (item.kind == KIND_FREE) begin
         if (held_blocks < CAPACITY) begin
            held_sizes[held_blocks] = item.block_size;
            held_offsets[held_blocks] = item.block_offset;
            held_blocks++;
         end else begin
            r.table_full = 1'b1;
         end
      end else begin
         for (int i = 0; i < held_blocks; i++) begin
            if (held_sizes[i] >= item.block_size &&
                (best < 0 || held_sizes[i] < held_sizes[best])) begin
               best = i;
            end
         end
         if (best >= 0) begin
            base = held_offsets[best];
            rest = held_sizes[best] - item.block_size;
            r.granted_offset = base;
            r.found = 1'b1;
            for (int i = best; i < held_blocks - 1; i++) begin
               held_sizes[i] = held_sizes[i + 1];
               held_offsets[i] = held_offsets[i + 1];
            end
            held_blocks--;
            if (rest != '0) begin
               held_sizes[held_blocks] = rest;
               held_offsets[held_blocks] = base + item.block_size;
               held_blocks++;
            end
         end
      end
      r.entry_count = CNT_W'(held_blocks);
      return r;
   endfunction

   function automatic void plan_row(logic kind, logic [VALUE_BITS-1:0] size,
                                    logic [VALUE_BITS-1:0] offset, int reps, logic typed,
                                    logic [VALUE_BITS-1:0] granted, logic found,
                                    logic full, int count);
      plan_row_type r;
      r.item = '{kind: kind, block_size: size, block_offset: offset};
      r.reps = 16'(reps);
      r.typed = typed;
      r.want = '{granted_offset: granted, found: found, table_full: full,
                 entry_count: CNT_W'(count)};
      plan.push_back(r);
   endfunction

   task automatic issue(req_type item, logic typed, rsp_type want);
      rsp_type predicted;
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = best_fit_step(item);
      pending_grants.push_back(typed ? want : predicted);
   endtask

   function automatic req_type random_item(int free_pct);
      req_type item;
      int      pick;
      item.block_offset = VALUE_BITS'($urandom);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < free_pct) begin
         item.kind = KIND_FREE;
         if (pick < 70) item.block_size = VALUE_BITS'($urandom_range(1, 64));
         else if (pick < 80) item.block_size = '0;
         else if (pick < 90) item.block_size = VALUE_BITS'($urandom);
         else if (pick < 95) item.block_size = VALUE_MAX;
         else item.block_size = VALUE_BITS'($urandom_range(1, 1000));
      end else begin
         item.kind = KIND_REQUEST;
         if (pick < 40) item.block_size = VALUE_BITS'($urandom_range(0, 64));
         else if (pick < 60 && held_blocks > 0)
            item.block_size = held_sizes[$urandom_range(0, held_blocks - 1)];
         else if (pick < 70) item.block_size = '0;
         else if (pick < 80) item.block_size = VALUE_BITS'($urandom);
         else if (pick < 85) item.block_size = VALUE_MAX;
         else item.block_size = VALUE_BITS'($urandom_range(1, 300));
      end
      return item;
   endfunction

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_grants.size() == 0) begin
            if (fail_count < 10) $display("Unexpected result transfer: %p", rsp_data);
            fail_count++;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_data.granted_offset !== want.granted_offset ||
                rsp_data.found !== want.found ||
                rsp_data.table_full !== want.table_full ||
                rsp_data.entry_count !== want.entry_count) begin
               if (fail_count < 10) begin
                  $display("Mismatch: expected offset=%h found=%b full=%b count=%0d",
                           want.granted_offset, want.found, want.table_full,
                           want.entry_count);
                  $display("          actual   offset=%h found=%b full=%b count=%0d",
                           rsp_data.granted_offset, rsp_data.found, rsp_data.table_full,
                           rsp_data.entry_count);
               end
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      req_type item;
      int      free_pct;
      // Each row: kind, size, offset, repeat, typed, then offset, found, full and count.
      // Rows that repeat use random sizes and offsets.
      plan_row(KIND_REQUEST, '0,          VALUE_MAX,  1, 1, '0, 0, 0, 0);
      plan_row(KIND_FREE,    100,         'h7FFFFFF0, 1, 1, '0, 0, 0, 1);
      plan_row(KIND_REQUEST, 30,          VALUE_MAX,  1, 1, 'h7FFFFFF0, 1, 0, 1);
      plan_row(KIND_REQUEST, 70,          '0,         1, 0, '0, 0, 0, 0);
      plan_row(KIND_FREE,    '0,          5,          1, 1, '0, 0, 0, 1);
      plan_row(KIND_FREE,    VALUE_MAX,   '0,         1, 1, '0, 0, 0, 2);
      plan_row(KIND_FREE,    50,          1000,       1, 1, '0, 0, 0, 3);
      plan_row(KIND_FREE,    50,          2000,       1, 1, '0, 0, 0, 4);
      plan_row(KIND_REQUEST, 40,          '0,         1, 0, '0, 0, 0, 0);
      plan_row(KIND_REQUEST, VALUE_MAX,   '0,         1, 1, '0, 1, 0, 3);
      plan_row(KIND_REQUEST, '0,          '0,         1, 0, '0, 0, 0, 0);
      plan_row(KIND_REQUEST, '0,          VALUE_MAX,  1, 0, '0, 0, 0, 0);
      plan_row(KIND_REQUEST, 100,         '0,         1, 1, '0, 0, 0, 2);
      plan_row(KIND_FREE,    '0,          '0,         DIRECTED_FILL, 0, '0, 0, 0, 0);
      plan_row(KIND_FREE,    7,           7,          1, 1, '0, 0, 1, CAPACITY);
      plan_row(KIND_REQUEST, VALUE_MAX,   VALUE_MAX,  1, 0, '0, 0, 0, 0);
      plan_row(KIND_REQUEST, 10,          '0,         1, 0, '0, 0, 0, 0);
      plan_row(KIND_REQUEST, '0,          '0,         1, 0, '0, 0, 0, 0);
      plan_row(KIND_FREE,    VALUE_MAX,   VALUE_MAX,  1, 0, '0, 0, 0, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[n]) begin
         for (int k = 0; k < plan[n].reps; k++) begin
            item = plan[n].item;
            if (plan[n].reps > 1) begin
               item.block_size = VALUE_BITS'($urandom_range(1, 200));
               item.block_offset = VALUE_BITS'($urandom);
            end
            issue(item, plan[n].typed, plan[n].want);
         end
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady <= (n >= 700 && n < 1000);
         case ((n / 150) % 4)
            0: free_pct = 50;
            1: free_pct = 95;
            2: free_pct = 20;
            default: free_pct = 70;
         endcase
         issue(random_item(free_pct), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
